// File: rtl/sats_pkg.sv
// sats_pkg: types, constants and microcode table for the serial angle to servo block
// no dependencies
`default_nettype none

package sats_pkg;

    localparam int MAX_ENTRY_CHARS = 9;
    localparam int CNT_W           = 4;
    localparam int PC_W            = 4;
    localparam int ITER_W          = 5;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_OOR  = 2'd2;

    localparam logic [1:0] REG_ANGLE_MIN = 2'd0;
    localparam logic [1:0] REG_ANGLE_MAX = 2'd1;
    localparam logic [1:0] REG_PULSE_MIN = 2'd2;
    localparam logic [1:0] REG_PULSE_MAX = 2'd3;

    localparam logic signed [15:0] ANGLE_MIN_RST = -16'sd90;
    localparam logic signed [15:0] ANGLE_MAX_RST = 16'sd90;
    localparam logic [15:0] PULSE_MIN_RST = 16'd125;
    localparam logic [15:0] PULSE_MAX_RST = 16'd625;
    localparam logic [15:0] COMPARE_RST   = 16'd500;

    typedef logic [PC_W-1:0] t_pc;

    typedef enum logic [1:0] {
        PH_WS     = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_FETCH,
        OP_PARSE,
        OP_SIGN,
        OP_RANGE,
        OP_MUL,
        OP_DIV,
        OP_FIN,
        OP_EMIT_ECHO,
        OP_EMIT_OK,
        OP_EMIT_OOR
    } t_op;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_ZERO,
        COND_TERM,
        COND_OUT_RANGE,
        COND_DIV_MORE
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_ctl;

    typedef struct packed {
        logic in_take;
        logic out_full;
        logic byte_zero;
        logic byte_term;
        logic in_range;
        logic div_more;
    } t_stat;

    localparam t_pc ST_FETCH    = 4'd0;
    localparam t_pc ST_ZCHK     = 4'd1;
    localparam t_pc ST_TCHK     = 4'd2;
    localparam t_pc ST_PARSE    = 4'd3;
    localparam t_pc ST_ECHO     = 4'd4;
    localparam t_pc ST_SIGN     = 4'd5;
    localparam t_pc ST_RANGE    = 4'd6;
    localparam t_pc ST_RCHK     = 4'd7;
    localparam t_pc ST_MUL      = 4'd8;
    localparam t_pc ST_DIV      = 4'd9;
    localparam t_pc ST_FIN      = 4'd10;
    localparam t_pc ST_EMIT_OK  = 4'd11;
    localparam t_pc ST_EMIT_OOR = 4'd12;

    function automatic t_ctl ucode(input t_pc pc);
        t_ctl w;
        case (pc)
            ST_FETCH:    w = '{OP_FETCH,     COND_NONE,      ST_FETCH};
            ST_ZCHK:     w = '{OP_NOP,       COND_ZERO,      ST_FETCH};
            ST_TCHK:     w = '{OP_NOP,       COND_TERM,      ST_SIGN};
            ST_PARSE:    w = '{OP_PARSE,     COND_NONE,      ST_FETCH};
            ST_ECHO:     w = '{OP_EMIT_ECHO, COND_ALWAYS,    ST_FETCH};
            ST_SIGN:     w = '{OP_SIGN,      COND_NONE,      ST_FETCH};
            ST_RANGE:    w = '{OP_RANGE,     COND_NONE,      ST_FETCH};
            ST_RCHK:     w = '{OP_NOP,       COND_OUT_RANGE, ST_EMIT_OOR};
            ST_MUL:      w = '{OP_MUL,       COND_NONE,      ST_FETCH};
            ST_DIV:      w = '{OP_DIV,       COND_DIV_MORE,  ST_DIV};
            ST_FIN:      w = '{OP_FIN,       COND_NONE,      ST_FETCH};
            ST_EMIT_OK:  w = '{OP_EMIT_OK,   COND_ALWAYS,    ST_FETCH};
            ST_EMIT_OOR: w = '{OP_EMIT_OOR,  COND_ALWAYS,    ST_FETCH};
            default:     w = '{OP_NOP,       COND_ALWAYS,    ST_FETCH};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: rtl/sats_in_if.sv
// sats_in_if: input channel carrying one received character per word
// no dependencies
`default_nettype none

interface sats_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/sats_out_if.sv
// sats_out_if: result channel with echo, angle and compare value
// no dependencies
`default_nettype none

interface sats_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [7:0]         echo_char;
    logic signed [30:0] angle;
    logic [15:0]        pulse_compare;

    modport source (output valid, output kind, output echo_char, output angle,
                    output pulse_compare, input ready);
    modport sink (input valid, input kind, input echo_char, input angle,
                  input pulse_compare, output ready);
endinterface

`default_nettype wire

// File: rtl/sats_useq.sv
// sats_useq: step counter and microcode table, picks next step from status
// depends on sats_pkg
`default_nettype none

module sats_useq
    import sats_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_stat i_stat,
    output t_ctl       o_ctl
);

    t_pc  r_pc;
    t_pc  n_pc;
    t_ctl w_ctl;
    logic w_hold;
    logic w_jump;

    assign w_ctl = ucode(r_pc);
    assign o_ctl = w_ctl;

    always_comb begin
        w_hold = 1'b0;
        case (w_ctl.op)
            OP_FETCH:                            w_hold = !i_stat.in_take;
            OP_EMIT_ECHO, OP_EMIT_OK, OP_EMIT_OOR: w_hold = i_stat.out_full;
            default:                             w_hold = 1'b0;
        endcase
        case (w_ctl.cond)
            COND_ALWAYS:    w_jump = 1'b1;
            COND_ZERO:      w_jump = i_stat.byte_zero;
            COND_TERM:      w_jump = i_stat.byte_term;
            COND_OUT_RANGE: w_jump = !i_stat.in_range;
            COND_DIV_MORE:  w_jump = i_stat.div_more;
            default:        w_jump = 1'b0;
        endcase
        if (w_hold) begin
            n_pc = r_pc;
        end else if (w_jump) begin
            n_pc = w_ctl.target;
        end else begin
            n_pc = r_pc + t_pc'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

`default_nettype wire

// File: rtl/sats_dp.sv
// sats_dp: parse state, config registers, map arithmetic, divider and result register
// depends on sats_pkg; driven by sats_useq control words
`default_nettype none

module sats_dp
    import sats_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_ctl        i_ctl,
    output t_stat            o_stat,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_in_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_out_kind,
    output logic [7:0]       o_out_echo,
    output logic [30:0]      o_out_angle,
    output logic [15:0]      o_out_pulse
);

    logic signed [15:0] r_amin;
    logic signed [15:0] r_amax;
    logic [15:0]        r_pmin;
    logic [15:0]        r_pmax;

    logic [7:0]         r_byte;
    logic [CNT_W-1:0]   r_count;
    t_phase             r_phase;
    logic               r_neg;
    logic [29:0]        r_accum;
    logic [15:0]        r_cmp;

    logic signed [30:0] r_angle;
    logic               r_inr;
    logic [15:0]        r_den;
    logic               r_qneg;
    logic [31:0]        r_quo;
    logic [15:0]        r_rem;
    logic [ITER_W-1:0]  r_iter;

    logic               r_ovalid;
    logic [1:0]         r_okind;
    logic [7:0]         r_oecho;
    logic [30:0]        r_oangle;
    logic [15:0]        r_opulse;

    logic               w_take;
    logic               w_full;
    logic               w_digit;
    logic               w_skip;
    logic [3:0]         w_dval;
    logic [29:0]        w_acc10;
    logic [30:0]        w_mag;
    logic signed [30:0] w_amin31;
    logic signed [30:0] w_amax31;
    logic [30:0]        w_diff31;
    logic [16:0]        w_dp;
    logic [16:0]        w_dpn;
    logic [15:0]        w_pmag;
    logic [16:0]        w_span;
    logic [16:0]        w_trial;
    logic [15:0]        w_q;
    logic [17:0]        w_qs;
    logic [17:0]        w_res;
    logic [15:0]        w_clamp;
    logic               w_emit;

    assign o_in_ready = (i_ctl.op == OP_FETCH);
    assign w_take     = i_in_valid && o_in_ready;
    assign w_full     = r_ovalid && !i_out_ready;

    assign o_stat.in_take   = w_take;
    assign o_stat.out_full  = w_full;
    assign o_stat.byte_zero = (r_byte == CH_NUL);
    assign o_stat.byte_term = (r_byte == CH_CR) || (r_byte == CH_SP);
    assign o_stat.in_range  = r_inr;
    assign o_stat.div_more  = (r_iter != {ITER_W{1'b1}});

    assign w_digit  = (r_byte >= CH_ZERO) && (r_byte <= CH_NINE);
    assign w_skip   = (r_byte >= CH_TAB) && (r_byte <= CH_FF);
    assign w_dval   = r_byte[3:0];
    assign w_acc10  = (r_accum << 3) + (r_accum << 1) + {26'd0, w_dval};
    assign w_mag    = {1'b0, r_accum};
    assign w_amin31 = {{15{r_amin[15]}}, r_amin};
    assign w_amax31 = {{15{r_amax[15]}}, r_amax};
    assign w_diff31 = r_angle - w_amin31;
    assign w_dp     = {1'b0, r_pmax} - {1'b0, r_pmin};
    assign w_dpn    = 17'd0 - w_dp;
    assign w_pmag   = w_dp[16] ? w_dpn[15:0] : w_dp[15:0];
    assign w_span   = {r_amax[15], r_amax} - {r_amin[15], r_amin};
    assign w_trial  = {r_rem, r_quo[31]} - {1'b0, r_den};
    assign w_q      = (r_den == 16'd0) ? 16'd0 : r_quo[15:0];
    assign w_qs     = r_qneg ? (18'd0 - {2'b00, w_q}) : {2'b00, w_q};
    assign w_res    = {2'b00, r_pmin} + w_qs;

    always_comb begin
        if (w_res[17]) begin
            w_clamp = 16'd0;
        end else if (w_res[16]) begin
            w_clamp = 16'hFFFF;
        end else begin
            w_clamp = w_res[15:0];
        end
        case (i_ctl.op)
            OP_EMIT_ECHO, OP_EMIT_OK, OP_EMIT_OOR: w_emit = !w_full;
            default:                             w_emit = 1'b0;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amin <= ANGLE_MIN_RST;
            r_amax <= ANGLE_MAX_RST;
            r_pmin <= PULSE_MIN_RST;
            r_pmax <= PULSE_MAX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ANGLE_MIN: r_amin <= i_cfg_data;
                REG_ANGLE_MAX: r_amax <= i_cfg_data;
                REG_PULSE_MIN: r_pmin <= i_cfg_data;
                REG_PULSE_MAX: r_pmax <= i_cfg_data;
                default:       r_amin <= r_amin;
            endcase
        end
    end

    // parse state and compare value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_phase <= PH_WS;
            r_neg   <= 1'b0;
            r_accum <= '0;
            r_cmp   <= COMPARE_RST;
        end else begin
            case (i_ctl.op)
                OP_PARSE: begin
                    if (r_count < CNT_W'(MAX_ENTRY_CHARS)) begin
                        r_count <= r_count + CNT_W'(1);
                        case (r_phase)
                            PH_WS: begin
                                if (w_skip) begin
                                    r_phase <= PH_WS;
                                end else if (r_byte == CH_PLUS || r_byte == CH_MINUS) begin
                                    r_neg   <= (r_byte == CH_MINUS);
                                    r_phase <= PH_SIGN;
                                end else if (w_digit) begin
                                    r_accum <= {26'd0, w_dval};
                                    r_phase <= PH_DIGITS;
                                end else begin
                                    r_phase <= PH_DONE;
                                end
                            end
                            PH_SIGN, PH_DIGITS: begin
                                if (w_digit) begin
                                    r_accum <= w_acc10;
                                    r_phase <= PH_DIGITS;
                                end else begin
                                    r_phase <= PH_DONE;
                                end
                            end
                            default: r_phase <= r_phase;
                        endcase
                    end
                end
                OP_FIN: r_cmp <= w_clamp;
                OP_EMIT_OK, OP_EMIT_OOR: begin
                    if (!w_full) begin
                        r_count <= '0;
                        r_phase <= PH_WS;
                        r_neg   <= 1'b0;
                        r_accum <= '0;
                    end
                end
                default: r_cmp <= r_cmp;
            endcase
        end
    end

    // arithmetic working registers
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_byte <= i_in_byte;
        end
        case (i_ctl.op)
            OP_SIGN:  r_angle <= r_neg ? (31'd0 - w_mag) : w_mag;
            OP_RANGE: r_inr <= (r_angle >= w_amin31) && (r_angle <= w_amax31);
            OP_MUL: begin
                r_quo  <= 32'(w_diff31[15:0]) * 32'(w_pmag);
                r_qneg <= w_dp[16];
                r_den  <= w_span[15:0];
                r_rem  <= '0;
                r_iter <= '0;
            end
            OP_DIV: begin
                r_iter <= r_iter + ITER_W'(1);
                if (!w_trial[16]) begin
                    r_rem <= w_trial[15:0];
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[14:0], r_quo[31]};
                    r_quo <= {r_quo[30:0], 1'b0};
                end
            end
            default: r_iter <= r_iter;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_opulse <= r_cmp;
            case (i_ctl.op)
                OP_EMIT_ECHO: begin
                    r_okind  <= KIND_ECHO;
                    r_oecho  <= r_byte;
                    r_oangle <= '0;
                end
                OP_EMIT_OK: begin
                    r_okind  <= KIND_OK;
                    r_oecho  <= '0;
                    r_oangle <= r_angle;
                end
                default: begin
                    r_okind  <= KIND_OOR;
                    r_oecho  <= '0;
                    r_oangle <= r_angle;
                end
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_kind  = r_okind;
    assign o_out_echo  = r_oecho;
    assign o_out_angle = r_oangle;
    assign o_out_pulse = r_opulse;

endmodule

`default_nettype wire

// File: rtl/serial_angle_to_servo_pulse.sv
// serial_angle_to_servo_pulse: top level, joins the microcode sequencer and the datapath
// depends on sats_pkg, sats_in_if, sats_out_if, sats_useq, sats_dp
//
// channel   dir  word                                       handshake
// i_in      in   rx_byte[7:0]                               valid/ready
// o_out     out  kind[1:0] echo_char[7:0] angle[30:0]       valid/ready
//                pulse_compare[15:0]
// cfg       in   i_cfg_idx[1:0] i_cfg_data[15:0]            i_cfg_we, no wait
//
// zero byte: dropped; any other non-terminator: parsed, then echoed through the result register
// carriage return or space: sign, range check, multiply, bit-serial divide, clamp, emit
// out-of-range angle: the range check goes straight to the out-of-range emit step
// one word in flight; a full result register stalls the emit step
// synchronous active-low reset restarts the sequencer at the fetch step
`default_nettype none

module serial_angle_to_servo_pulse
    import sats_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    sats_in_if.sink          i_in,
    sats_out_if.source       o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);

    t_ctl        w_ctl;
    t_stat       w_stat;
    logic [30:0] w_angle;

    sats_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctl   (w_ctl)
    );

    sats_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .o_stat      (w_stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_in_byte   (i_in.rx_byte),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_kind  (o_out.kind),
        .o_out_echo  (o_out.echo_char),
        .o_out_angle (w_angle),
        .o_out_pulse (o_out.pulse_compare)
    );

    assign o_out.angle = w_angle;

endmodule

`default_nettype wire

// File: rtl/sats_chk.sv
// sats_chk: port-level checks on the top level, attached by bind
// depends on sats_pkg and serial_angle_to_servo_pulse
`default_nettype none

module sats_chk
    import sats_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [1:0]  i_out_kind,
    input wire logic [7:0]  i_out_echo,
    input wire logic [30:0] i_out_angle,
    input wire logic [15:0] i_out_pulse
);

    // no result word right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // one word at a time: no acceptance in the cycle after one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted on consecutive cycles");

    // echoed characters are never zero or terminators and carry no angle
    a_echo_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == KIND_ECHO |->
            i_out_angle == 31'd0 && i_out_echo != CH_NUL &&
            i_out_echo != CH_CR && i_out_echo != CH_SP)
        else $error("bad echo word");

    // angle words carry no echo character
    a_angle_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind != KIND_ECHO |-> i_out_echo == 8'd0)
        else $error("echo character on angle word");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_kind) && $stable(i_out_angle) &&
            $stable(i_out_pulse))
        else $error("stalled result changed");

endmodule

bind serial_angle_to_servo_pulse sats_chk u_sats_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.kind),
    .i_out_echo  (o_out.echo_char),
    .i_out_angle (o_out.angle),
    .i_out_pulse (o_out.pulse_compare)
);

`default_nettype wire
